FILE: rtl/core/aabb_pkg.sv
// ---------------------------------------------------------------------------
// aabb_pkg: shared widths and types for the box pair collision resolver
// Field widths, divider widths and the side-band record carried beside the
// divider lanes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aabb_pkg;

  localparam int POS_W   = 32;             // left/top edge
  localparam int SIZE_W  = 24;             // width/height
  localparam int INV_W   = 16;             // inverse mass
  localparam int FLAG_W  = 3;              // pair flags
  localparam int DELTA_W = 26;             // position delta
  localparam int CTR_W   = POS_W + 3;      // doubled center and its difference
  localparam int OVS_W   = CTR_W + 1;      // signed overlap
  localparam int OV_W    = SIZE_W + 1;     // overlap when in contact
  localparam int SUM_W   = INV_W + 1;      // inverse mass sum
  localparam int DEN_W   = SUM_W + 1;      // divisor, 2 * sum
  localparam int NUM_W   = OV_W + INV_W;   // dividend, overlap * inverse mass
  localparam int QUO_W   = SIZE_W;         // each share is below 2^24

  localparam int FLAG_BODY_A = 0;
  localparam int FLAG_BODY_B = 1;
  localparam int FLAG_TRIG   = 2;

  typedef enum logic {
    AXIS_X = 1'b0,
    AXIS_Y = 1'b1
  } axis_t;

  // per-item control that rides along with the divider
  typedef struct packed {
    logic  contact;
    logic  resolved;
    axis_t axis;
    logic  d_pos;      // center distance on push axis is positive
    logic  body_a;
    logic  body_b;
  } side_t;

endpackage

`default_nettype wire

FILE: rtl/core/aabb_div_pipe.sv
// ---------------------------------------------------------------------------
// aabb_div_pipe: two-lane pipelined restoring divider
// One quotient bit per stage, both lanes share the divisor; a side record
// travels with each item. Per-stage valid bits, ready chain collapses bubbles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_div_pipe (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [aabb_pkg::NUM_W-1:0]   in_num_a,
  input  wire logic [aabb_pkg::NUM_W-1:0]   in_num_b,
  input  wire logic [aabb_pkg::DEN_W-1:0]   in_den,
  input  wire aabb_pkg::side_t              in_side,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [aabb_pkg::QUO_W-1:0]        out_quo_a,
  output logic [aabb_pkg::QUO_W-1:0]        out_quo_b,
  output aabb_pkg::side_t                   out_side
);
  import aabb_pkg::*;

  logic [NUM_W-1:0] rem_a [QUO_W];
  logic [NUM_W-1:0] rem_b [QUO_W];
  logic [QUO_W-1:0] quo_a [QUO_W];
  logic [QUO_W-1:0] quo_b [QUO_W];
  logic [DEN_W-1:0] den   [QUO_W];
  side_t            side  [QUO_W];
  logic [QUO_W-1:0] vld;
  logic [QUO_W-1:0] en;

  always_comb begin
    en[QUO_W-1] = !vld[QUO_W-1] || out_ready;
    for (int s = QUO_W - 2; s >= 0; s--) begin
      en[s] = !vld[s] || en[s+1];
    end
  end

  assign in_ready = en[0];

  genvar g;
  generate
    for (g = 0; g < QUO_W; g++) begin : g_stage
      localparam int K = QUO_W - 1 - g;
      logic [NUM_W-1:0] src_a, src_b;
      logic [QUO_W-1:0] src_qa, src_qb;
      logic [DEN_W-1:0] src_den;
      side_t            src_side;
      logic             src_vld;
      logic [NUM_W:0]   dsh, trial_a, trial_b;

      if (g == 0) begin : g_first
        assign src_a    = in_num_a;
        assign src_b    = in_num_b;
        assign src_qa   = '0;
        assign src_qb   = '0;
        assign src_den  = in_den;
        assign src_side = in_side;
        assign src_vld  = in_valid;
      end else begin : g_next
        assign src_a    = rem_a[g-1];
        assign src_b    = rem_b[g-1];
        assign src_qa   = quo_a[g-1];
        assign src_qb   = quo_b[g-1];
        assign src_den  = den[g-1];
        assign src_side = side[g-1];
        assign src_vld  = vld[g-1];
      end

      // divisor aligned to this quotient bit; it fits since the quotient does
      assign dsh     = {{(NUM_W + 1 - DEN_W){1'b0}}, src_den} << K;
      assign trial_a = {1'b0, src_a} - dsh;
      assign trial_b = {1'b0, src_b} - dsh;

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[g] <= 1'b0;
        end else if (en[g]) begin
          vld[g] <= src_vld;
        end
      end

      always_ff @(posedge clk) begin
        if (en[g]) begin
          rem_a[g] <= trial_a[NUM_W] ? src_a : trial_a[NUM_W-1:0];
          rem_b[g] <= trial_b[NUM_W] ? src_b : trial_b[NUM_W-1:0];
          quo_a[g] <= {src_qa[QUO_W-2:0], !trial_a[NUM_W]};
          quo_b[g] <= {src_qb[QUO_W-2:0], !trial_b[NUM_W]};
          den[g]   <= src_den;
          side[g]  <= src_side;
        end
      end
    end
  endgenerate

  assign out_valid = vld[QUO_W-1];
  assign out_quo_a = quo_a[QUO_W-1];
  assign out_quo_b = quo_b[QUO_W-1];
  assign out_side  = side[QUO_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/aabb_pair_collision_resolver_unit.sv
// ---------------------------------------------------------------------------
// aabb_pair_collision_resolver_unit: box pair overlap and push split
// Finds per-axis overlap of two axis-aligned boxes, picks the axis of least
// penetration (tie to Y) and splits the push by inverse mass.
// ---------------------------------------------------------------------------
//
//  channel   dir  payload                                  transfer when
//  s_axis    in   tdata: two boxes, tuser: pair flags      tvalid & tready
//  m_axis    out  tdata: deltas, tuser: contact/flags      tvalid & tready
//
// One pair per cycle sustained while m_axis is ready. The path is 4 front stages,
// 24 divider stages (one quotient bit each) and 1 output register; the divider depth
// follows from the 24-bit share width.
// Synchronous active-high rst clears all valid bits; payload is not reset.
// Each stage moves when its successor has room, so bubbles close up and a
// stall on m_axis never drops or repeats a transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_pair_collision_resolver_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] a_x, [63:32] a_y, [87:64] a_w, [111:88] a_h, [127:112] a_inv_mass,
  // [159:128] b_x, [191:160] b_y, [215:192] b_w, [239:216] b_h,
  // [255:240] b_inv_mass
  input  wire logic [255:0] s_axis_tdata,
  // [2:0] pair_flags
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [25:0] delta_a, [51:26] delta_b, [55:52] zero
  output logic [55:0]       m_axis_tdata,
  // [0] contact, [1] resolved, [2] push_axis, [3] clear_vel_a, [4] clear_vel_b
  output logic [4:0]        m_axis_tuser
);
  import aabb_pkg::*;

  // ---- input unpack ----
  logic [POS_W-1:0]  a_x, a_y, b_x, b_y;
  logic [SIZE_W-1:0] a_w, a_h, b_w, b_h;
  logic [INV_W-1:0]  a_inv_mass, b_inv_mass;
  logic [FLAG_W-1:0] pair_flags;

  assign a_x        = s_axis_tdata[31:0];
  assign a_y        = s_axis_tdata[63:32];
  assign a_w        = s_axis_tdata[87:64];
  assign a_h        = s_axis_tdata[111:88];
  assign a_inv_mass = s_axis_tdata[127:112];
  assign b_x        = s_axis_tdata[159:128];
  assign b_y        = s_axis_tdata[191:160];
  assign b_w        = s_axis_tdata[215:192];
  assign b_h        = s_axis_tdata[239:216];
  assign b_inv_mass = s_axis_tdata[255:240];
  assign pair_flags = s_axis_tuser;

  // ---- handshake chain ----
  logic v1, v2, v3, v4, vo;
  logic en1, en2, en3, en4, eno;
  logic div_in_ready, div_out_valid;

  assign eno = !vo || m_axis_tready;
  assign en4 = !v4 || div_in_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en1) v1 <= s_axis_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (eno) vo <= div_out_valid;
    end
  end

  // ---- stage 1: doubled center distance, size sums, effective masses ----
  logic [CTR_W-1:0]  cax, cay, cbx, cby;
  logic [CTR_W-1:0]  s1_dx, s1_dy;
  logic [OV_W-1:0]   s1_sx, s1_sy;
  logic [INV_W-1:0]  s1_ia, s1_ib;
  logic              s1_trig, s1_body_a, s1_body_b;

  // 2*pos + size, sign-extended to CTR_W
  assign cax = {{(CTR_W-POS_W-1){a_x[POS_W-1]}}, a_x, 1'b0} + {{(CTR_W-SIZE_W){1'b0}}, a_w};
  assign cay = {{(CTR_W-POS_W-1){a_y[POS_W-1]}}, a_y, 1'b0} + {{(CTR_W-SIZE_W){1'b0}}, a_h};
  assign cbx = {{(CTR_W-POS_W-1){b_x[POS_W-1]}}, b_x, 1'b0} + {{(CTR_W-SIZE_W){1'b0}}, b_w};
  assign cby = {{(CTR_W-POS_W-1){b_y[POS_W-1]}}, b_y, 1'b0} + {{(CTR_W-SIZE_W){1'b0}}, b_h};

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_dx     <= cax - cbx;
      s1_dy     <= cay - cby;
      s1_sx     <= {1'b0, a_w} + {1'b0, b_w};
      s1_sy     <= {1'b0, a_h} + {1'b0, b_h};
      s1_ia     <= pair_flags[FLAG_BODY_A] ? a_inv_mass : '0;
      s1_ib     <= pair_flags[FLAG_BODY_B] ? b_inv_mass : '0;
      s1_trig   <= pair_flags[FLAG_TRIG];
      s1_body_a <= pair_flags[FLAG_BODY_A];
      s1_body_b <= pair_flags[FLAG_BODY_B];
    end
  end

  // ---- stage 2: overlaps, mass sum ----
  logic [CTR_W-1:0] abs_dx, abs_dy;
  logic [OVS_W-1:0] s2_ovx, s2_ovy;
  logic             s2_dx_pos, s2_dy_pos;
  logic [SUM_W-1:0] s2_sum;
  logic [INV_W-1:0] s2_ia, s2_ib;
  logic             s2_trig, s2_body_a, s2_body_b;

  assign abs_dx = s1_dx[CTR_W-1] ? (~s1_dx + 1'b1) : s1_dx;
  assign abs_dy = s1_dy[CTR_W-1] ? (~s1_dy + 1'b1) : s1_dy;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_ovx    <= {{(OVS_W-OV_W){1'b0}}, s1_sx} - {1'b0, abs_dx};
      s2_ovy    <= {{(OVS_W-OV_W){1'b0}}, s1_sy} - {1'b0, abs_dy};
      s2_dx_pos <= !s1_dx[CTR_W-1] && (s1_dx != '0);
      s2_dy_pos <= !s1_dy[CTR_W-1] && (s1_dy != '0);
      s2_sum    <= {1'b0, s1_ia} + {1'b0, s1_ib};
      s2_ia     <= s1_ia;
      s2_ib     <= s1_ib;
      s2_trig   <= s1_trig;
      s2_body_a <= s1_body_a;
      s2_body_b <= s1_body_b;
    end
  end

  // ---- stage 3: contact, axis choice ----
  logic  ovx_gt0, ovy_gt0, x_less, contact_c;
  side_t s3_side;
  logic [OV_W-1:0]  s3_ov;
  logic [INV_W-1:0] s3_ia, s3_ib;
  logic [DEN_W-1:0] s3_den;

  assign ovx_gt0   = !s2_ovx[OVS_W-1] && (s2_ovx != '0);
  assign ovy_gt0   = !s2_ovy[OVS_W-1] && (s2_ovy != '0);
  assign x_less    = $signed(s2_ovx) < $signed(s2_ovy);
  assign contact_c = ovx_gt0 && ovy_gt0;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_side.contact  <= contact_c;
      s3_side.resolved <= contact_c && !s2_trig && (s2_sum != '0);
      s3_side.axis     <= x_less ? AXIS_X : AXIS_Y;
      s3_side.d_pos    <= x_less ? s2_dx_pos : s2_dy_pos;
      s3_side.body_a   <= s2_body_a;
      s3_side.body_b   <= s2_body_b;
      // in contact the chosen overlap is positive and below 2^OV_W
      s3_ov            <= x_less ? s2_ovx[OV_W-1:0] : s2_ovy[OV_W-1:0];
      s3_ia            <= s2_ia;
      s3_ib            <= s2_ib;
      s3_den           <= {s2_sum, 1'b0};
    end
  end

  // ---- stage 4: dividends ----
  side_t            s4_side;
  logic [NUM_W-1:0] s4_na, s4_nb;
  logic [DEN_W-1:0] s4_den;

  // operands widened to the full product width
  always_ff @(posedge clk) begin
    if (en4) begin
      s4_side <= s3_side;
      s4_na   <= {{INV_W{1'b0}}, s3_ov} * {{OV_W{1'b0}}, s3_ia};
      s4_nb   <= {{INV_W{1'b0}}, s3_ov} * {{OV_W{1'b0}}, s3_ib};
      s4_den  <= s3_den;
    end
  end

  // ---- divider: share = ov * inv / (2 * sum) ----
  logic [QUO_W-1:0] qa, qb;
  side_t            dv_side;

  aabb_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_ready  (div_in_ready),
    .in_num_a  (s4_na),
    .in_num_b  (s4_nb),
    .in_den    (s4_den),
    .in_side   (s4_side),
    .out_valid (div_out_valid),
    .out_ready (eno),
    .out_quo_a (qa),
    .out_quo_b (qb),
    .out_side  (dv_side)
  );

  // ---- output register: sign the shares, gate on resolved ----
  logic [DELTA_W-1:0] pa, pb, da_c, db_c;
  logic [DELTA_W-1:0] o_da, o_db;
  logic               o_contact, o_resolved, o_axis, o_clr_a, o_clr_b;

  assign pa = {{(DELTA_W-QUO_W){1'b0}}, qa};
  assign pb = {{(DELTA_W-QUO_W){1'b0}}, qb};
  // positive distance: A moves up the axis, B down; zero distance goes the other way
  assign da_c = dv_side.d_pos ? pa : (~pa + 1'b1);
  assign db_c = dv_side.d_pos ? (~pb + 1'b1) : pb;

  always_ff @(posedge clk) begin
    if (eno) begin
      o_contact  <= dv_side.contact;
      o_resolved <= dv_side.resolved;
      o_axis     <= dv_side.resolved && (dv_side.axis == AXIS_Y);
      o_da       <= dv_side.resolved ? da_c : '0;
      o_db       <= dv_side.resolved ? db_c : '0;
      o_clr_a    <= dv_side.resolved && dv_side.body_a;
      o_clr_b    <= dv_side.resolved && dv_side.body_b;
    end
  end

  assign m_axis_tvalid = vo;
  assign m_axis_tdata  = {4'b0, o_db, o_da};
  assign m_axis_tuser  = {o_clr_b, o_clr_a, o_axis, o_resolved, o_contact};

  // ---- assertions ----
  a_resolved_needs_contact: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("resolved without contact");

  a_unresolved_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |-> (m_axis_tdata == '0) && (m_axis_tuser[4:2] == '0))
    else $error("push output without resolution");

  a_front_room: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> s_axis_tready)
    else $error("input stalled with empty first stage");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    vo && !m_axis_tready |=> vo && $stable(m_axis_tdata))
    else $error("output changed under stall");

endmodule

`default_nettype wire
